/* rtl/baro_second_order_compensation_macros.svh */
// Assertion macros shared by the checker of the barometer compensation block.
// No dependencies; take in by `include where assertions are written.
`ifndef BARO_SECOND_ORDER_COMPENSATION_MACROS_SVH
`define BARO_SECOND_ORDER_COMPENSATION_MACROS_SVH

// Same-cycle implication, checked while en is high.
`define BSC_ASSERT_NOW(label, clk, en, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(en)) (ante) |-> (cons)) \
        else $error("bsc assertion failed");

// Next-cycle implication, checked while en is high.
`define BSC_ASSERT_NEXT(label, clk, en, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(en)) (ante) |=> (cons)) \
        else $error("bsc assertion failed");

`endif

/* rtl/bsc_pkg.sv */
// Shared types and constants of the barometer compensation block.
// No dependencies; used by bsc_pipe_ctrl, the top level and the checker.
`default_nettype none

package bsc_pkg;

    // Pipeline depth: transaction accepted into stage 0, result held in the last stage.
    localparam int NSTAGE = 10;

    // Configuration register indexes.
    localparam logic [2:0] REG_SENS        = 3'd0;
    localparam logic [2:0] REG_OFFSET      = 3'd1;
    localparam logic [2:0] REG_SENS_TEMP   = 3'd2;
    localparam logic [2:0] REG_OFFSET_TEMP = 3'd3;
    localparam logic [2:0] REG_REF_TEMP    = 3'd4;
    localparam logic [2:0] REG_TEMP_SLOPE  = 3'd5;

    localparam logic signed [19:0] TEMP_REF     = 20'sd2000;
    localparam logic signed [19:0] TEMP_LOW     = -20'sd1500;
    localparam logic signed [28:0] PRESSURE_MAX = 29'sd120000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PRESS = 2'd1,
        ST_BAD_TEMP  = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic              out_valid;
    } t_pipe_ctrl;

endpackage

`default_nettype wire

/* rtl/bsc_pipe_ctrl.sv */
// Valid bits and per-stage load enables of the compensation pipeline.
// Depends on bsc_pkg.
`default_nettype none

module bsc_pipe_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_out_ready,
    output bsc_pkg::t_pipe_ctrl      o_ctrl
);

    logic [bsc_pkg::NSTAGE-1:0] r_vld;
    logic [bsc_pkg::NSTAGE-1:0] n_vld;
    logic [bsc_pkg::NSTAGE-1:0] w_en;
    logic [bsc_pkg::NSTAGE-1:0] w_shift;

    // A stage may load when any stage from it to the output is empty,
    // or when the output is being taken. Bubbles collapse this way.
    for (genvar k = 0; k < bsc_pkg::NSTAGE; k++) begin : g_en
        assign w_en[k] = i_out_ready | ~(&r_vld[bsc_pkg::NSTAGE-1:k]);
    end

    assign w_shift = {r_vld[bsc_pkg::NSTAGE-2:0], i_in_valid};

    always_comb begin
        n_vld = (w_en & w_shift) | (~w_en & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctrl.en        = w_en;
    assign o_ctrl.out_valid = r_vld[bsc_pkg::NSTAGE-1];

endmodule

`default_nettype wire

/* rtl/baro_second_order_compensation.sv */
// A transaction accepted into stage 0 passes stages 1 to 8 to its result on o_out_valid at stage 9.
// Throughput: one transaction per cycle unless the output stalls; ten pipeline stages,
// and all stages advance together unless the output stalls.
// Reset (synchronous, active low) clears the six coefficients and all valid bits.
// Depends on bsc_pkg and bsc_pipe_ctrl.
`default_nettype none

module baro_second_order_compensation (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [23:0]        i_pressure_raw,
    input  wire logic [23:0]        i_temperature_raw,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [16:0]             o_pressure_comp,
    output logic signed [19:0]      o_temperature_centi,
    output logic [1:0]              o_status
);

    bsc_pkg::t_pipe_ctrl w_ctrl;

    // Calibration words C1..C6
    logic [15:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bsc_pkg::REG_SENS:        r_c1 <= i_cfg_data;
                bsc_pkg::REG_OFFSET:      r_c2 <= i_cfg_data;
                bsc_pkg::REG_SENS_TEMP:   r_c3 <= i_cfg_data;
                bsc_pkg::REG_OFFSET_TEMP: r_c4 <= i_cfg_data;
                bsc_pkg::REG_REF_TEMP:    r_c5 <= i_cfg_data;
                bsc_pkg::REG_TEMP_SLOPE:  r_c6 <= i_cfg_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    bsc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_ctrl      (w_ctrl)
    );

    // ---------------- stage 0: dT and raw word checks
    logic                  w_bad_p, w_bad_t;
    logic signed [24:0]    n_s0_dt, r_s0_dt;
    logic [23:0]           r_s0_d1;
    bsc_pkg::t_status      n_s0_st, r_s0_st;

    assign w_bad_p = (i_pressure_raw == '0) || (i_pressure_raw == '1);
    assign w_bad_t = (i_temperature_raw == '0) || (i_temperature_raw == '1);

    always_comb begin
        n_s0_dt = {1'b0, i_temperature_raw} - {1'b0, r_c5, 8'b0};
        priority if (w_bad_p) begin
            n_s0_st = bsc_pkg::ST_BAD_PRESS;
        end else if (w_bad_t) begin
            n_s0_st = bsc_pkg::ST_BAD_TEMP;
        end else begin
            n_s0_st = bsc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[0]) begin
            r_s0_dt <= n_s0_dt;
            r_s0_d1 <= i_pressure_raw;
            r_s0_st <= n_s0_st;
        end
    end

    // ---------------- stage 1: products with dT
    logic signed [41:0]    n_s1_mt, n_s1_moff, n_s1_msens;
    logic signed [41:0]    r_s1_mt, r_s1_moff, r_s1_msens;
    logic signed [49:0]    n_s1_mdt2, r_s1_mdt2;
    logic [23:0]           r_s1_d1;
    bsc_pkg::t_status      r_s1_st;

    assign n_s1_mt    = r_s0_dt * $signed({1'b0, r_c6});
    assign n_s1_moff  = r_s0_dt * $signed({1'b0, r_c4});
    assign n_s1_msens = r_s0_dt * $signed({1'b0, r_c3});
    assign n_s1_mdt2  = r_s0_dt * r_s0_dt;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[1]) begin
            r_s1_mt    <= n_s1_mt;
            r_s1_moff  <= n_s1_moff;
            r_s1_msens <= n_s1_msens;
            r_s1_mdt2  <= n_s1_mdt2;
            r_s1_d1    <= r_s0_d1;
            r_s1_st    <= r_s0_st;
        end
    end

    // ---------------- stage 2: first-order TEMP, OFF, SENS and T2
    logic signed [19:0]    n_s2_temp1, r_s2_temp1;
    logic [40:0]           n_s2_off1, r_s2_off1;
    logic [39:0]           n_s2_sens1, r_s2_sens1;
    logic [16:0]           n_s2_t2, r_s2_t2;
    logic [23:0]           r_s2_d1;
    bsc_pkg::t_status      r_s2_st;

    // arithmetic shifts are floor divisions: keep the sign bit on top
    assign n_s2_temp1 = bsc_pkg::TEMP_REF + {r_s1_mt[41], r_s1_mt[41:23]};
    assign n_s2_off1  = {{5{r_s1_moff[41]}}, r_s1_moff[41:6]} + {8'b0, r_c2, 17'b0};
    assign n_s2_sens1 = {{5{r_s1_msens[41]}}, r_s1_msens[41:7]} + {8'b0, r_c1, 16'b0};
    assign n_s2_t2    = r_s1_mdt2[47:31];

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[2]) begin
            r_s2_temp1 <= n_s2_temp1;
            r_s2_off1  <= n_s2_off1;
            r_s2_sens1 <= n_s2_sens1;
            r_s2_t2    <= n_s2_t2;
            r_s2_d1    <= r_s1_d1;
            r_s2_st    <= r_s1_st;
        end
    end

    // ---------------- stage 3: squares of the distance below 20 C and -15 C
    logic signed [19:0]    w_dh, w_dl;
    logic signed [39:0]    w_sq_h, w_sq_l;
    logic                  n_s3_low1, n_s3_low2, r_s3_low1, r_s3_low2;
    logic [33:0]           r_s3_sq_h, r_s3_sq_l;
    logic signed [19:0]    n_s3_temp, r_s3_temp;
    logic [40:0]           r_s3_off1;
    logic [39:0]           r_s3_sens1;
    logic [23:0]           r_s3_d1;
    bsc_pkg::t_status      r_s3_st;

    assign w_dh      = r_s2_temp1 - bsc_pkg::TEMP_REF;
    assign w_dl      = r_s2_temp1 - bsc_pkg::TEMP_LOW;
    assign w_sq_h    = w_dh * w_dh;
    assign w_sq_l    = w_dl * w_dl;
    assign n_s3_low1 = r_s2_temp1 < bsc_pkg::TEMP_REF;
    assign n_s3_low2 = r_s2_temp1 < bsc_pkg::TEMP_LOW;
    assign n_s3_temp = r_s2_temp1 - (n_s3_low1 ? {3'b0, r_s2_t2} : 20'b0);

    // Squares are used only below the threshold, where they stay under 2^34.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[3]) begin
            r_s3_low1  <= n_s3_low1;
            r_s3_low2  <= n_s3_low2;
            r_s3_sq_h  <= w_sq_h[33:0];
            r_s3_sq_l  <= w_sq_l[33:0];
            r_s3_temp  <= n_s3_temp;
            r_s3_off1  <= r_s2_off1;
            r_s3_sens1 <= r_s2_sens1;
            r_s3_d1    <= r_s2_d1;
            r_s3_st    <= r_s2_st;
        end
    end

    // ---------------- stage 4: scaled second-order terms
    logic [39:0]           n_s4_m61, r_s4_m61;
    logic [37:0]           n_s4_m15, r_s4_m15;
    logic [37:0]           n_s4_sens2, r_s4_sens2;
    logic signed [19:0]    r_s4_temp;
    logic [40:0]           r_s4_off1;
    logic [39:0]           r_s4_sens1;
    logic [23:0]           r_s4_d1;
    bsc_pkg::t_status      r_s4_st;

    // 61*x = 64x - 4x + x, 15*x = 16x - x
    assign n_s4_m61 = r_s3_low1 ?
        ({r_s3_sq_h, 6'b0} - {4'b0, r_s3_sq_h, 2'b0} + {6'b0, r_s3_sq_h}) : 40'b0;
    assign n_s4_m15 = r_s3_low2 ? ({r_s3_sq_l, 4'b0} - {4'b0, r_s3_sq_l}) : 38'b0;
    assign n_s4_sens2 = r_s3_low1 ?
        ({3'b0, r_s3_sq_h, 1'b0} + (r_s3_low2 ? {1'b0, r_s3_sq_l, 3'b0} : 38'b0)) : 38'b0;

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[4]) begin
            r_s4_m61   <= n_s4_m61;
            r_s4_m15   <= n_s4_m15;
            r_s4_sens2 <= n_s4_sens2;
            r_s4_temp  <= r_s3_temp;
            r_s4_off1  <= r_s3_off1;
            r_s4_sens1 <= r_s3_sens1;
            r_s4_d1    <= r_s3_d1;
            r_s4_st    <= r_s3_st;
        end
    end

    // ---------------- stage 5: OFF2 and final SENS
    logic [38:0]           n_s5_off2, r_s5_off2;
    logic [39:0]           n_s5_sens, r_s5_sens;
    logic signed [19:0]    r_s5_temp;
    logic [40:0]           r_s5_off1;
    logic [23:0]           r_s5_d1;
    bsc_pkg::t_status      r_s5_st;

    assign n_s5_off2 = {3'b0, r_s4_m61[39:4]} + {1'b0, r_s4_m15};
    assign n_s5_sens = r_s4_sens1 - {2'b0, r_s4_sens2};

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[5]) begin
            r_s5_off2 <= n_s5_off2;
            r_s5_sens <= n_s5_sens;
            r_s5_temp <= r_s4_temp;
            r_s5_off1 <= r_s4_off1;
            r_s5_d1   <= r_s4_d1;
            r_s5_st   <= r_s4_st;
        end
    end

    // ---------------- stage 6: final OFF, D1*SENS as two partial products
    logic [40:0]           n_s6_off, r_s6_off;
    logic [43:0]           n_s6_pl, r_s6_pl;
    logic signed [44:0]    w_ph;
    logic [43:0]           r_s6_ph;
    logic signed [19:0]    r_s6_temp;
    bsc_pkg::t_status      r_s6_st;

    assign n_s6_off = r_s5_off1 - {2'b0, r_s5_off2};
    assign n_s6_pl  = r_s5_d1 * r_s5_sens[19:0];
    assign w_ph     = $signed({1'b0, r_s5_d1}) * $signed(r_s5_sens[39:20]);

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[6]) begin
            r_s6_off  <= n_s6_off;
            r_s6_pl   <= n_s6_pl;
            r_s6_ph   <= w_ph[43:0];
            r_s6_temp <= r_s5_temp;
            r_s6_st   <= r_s5_st;
        end
    end

    // ---------------- stage 7: combine partial products
    logic [63:0]           n_s7_prod, r_s7_prod;
    logic [40:0]           r_s7_off;
    logic signed [19:0]    r_s7_temp;
    bsc_pkg::t_status      r_s7_st;

    assign n_s7_prod = {r_s6_ph, 20'b0} + {20'b0, r_s6_pl};

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[7]) begin
            r_s7_prod <= n_s7_prod;
            r_s7_off  <= r_s6_off;
            r_s7_temp <= r_s6_temp;
            r_s7_st   <= r_s6_st;
        end
    end

    // ---------------- stage 8: (D1*SENS >> 21) - OFF
    logic [43:0]           n_s8_y, r_s8_y;
    logic signed [19:0]    r_s8_temp;
    bsc_pkg::t_status      r_s8_st;

    assign n_s8_y = {r_s7_prod[63], r_s7_prod[63:21]} - {{3{r_s7_off[40]}}, r_s7_off};

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[8]) begin
            r_s8_y    <= n_s8_y;
            r_s8_temp <= r_s7_temp;
            r_s8_st   <= r_s7_st;
        end
    end

    // ---------------- stage 9: range check, status, output register
    logic signed [28:0]    w_p;
    logic                  w_in_range;
    bsc_pkg::t_status      n_s9_st, r_s9_st;
    logic [16:0]           n_s9_press, r_s9_press;
    logic signed [19:0]    r_s9_temp;

    assign w_p        = r_s8_y[43:15];
    assign w_in_range = (w_p > 0) && (w_p <= bsc_pkg::PRESSURE_MAX);

    always_comb begin
        priority if (r_s8_st != bsc_pkg::ST_OK) begin
            n_s9_st = r_s8_st;
        end else if (w_in_range) begin
            n_s9_st = bsc_pkg::ST_OK;
        end else begin
            n_s9_st = bsc_pkg::ST_RANGE;
        end
        n_s9_press = (n_s9_st == bsc_pkg::ST_OK) ? w_p[16:0] : 17'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[9]) begin
            r_s9_st    <= n_s9_st;
            r_s9_press <= n_s9_press;
            r_s9_temp  <= r_s8_temp;
        end
    end

    assign o_in_ready          = w_ctrl.en[0];
    assign o_out_valid         = w_ctrl.out_valid;
    assign o_pressure_comp     = r_s9_press;
    assign o_temperature_centi = r_s9_temp;
    assign o_status            = r_s9_st;

endmodule

`default_nettype wire

/* rtl/bsc_checker.sv */
// Port-level checker of the barometer compensation block, bound to the top level.
// Depends on bsc_pkg and baro_second_order_compensation_macros.svh.
`default_nettype none

`include "baro_second_order_compensation_macros.svh"

module bsc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [16:0]        o_pressure_comp,
    input wire logic signed [19:0] o_temperature_centi,
    input wire logic [1:0]         o_status
);

    // stalled result holds
    `BSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pressure_comp) && $stable(o_temperature_centi) && $stable(o_status))

    // reset empties the pipeline
    `BSC_ASSERT_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)

    // an empty output stage never blocks the input side
    `BSC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // any error zeroes the pressure
    `BSC_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_status != bsc_pkg::ST_OK), o_pressure_comp == 17'd0)

    // good status means a pressure within 1 Pa .. 120000 Pa
    `BSC_ASSERT_NOW(a_ok_range, i_clk, i_rst_n, o_out_valid && (o_status == bsc_pkg::ST_OK), (o_pressure_comp != 17'd0) && (o_pressure_comp <= 17'd120000))

endmodule

bind baro_second_order_compensation bsc_checker u_bsc_checker (.*);

`default_nettype wire
